// ===== hw/rtl/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg
// shared types, constants and fixed-point helpers for the stereo reverb
// ----------------------------------------------------------------------------
`default_nettype none

package scr_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int DEF_MAX_TAPS       = 4096;
    localparam int DEF_PREDELAY_DEPTH = 8192;
    localparam int ONE_Q15            = 32768;

    localparam int MIX_W      = 16;
    localparam int PREDELAY_W = 13;
    localparam int WIDTH_W    = 16;
    localparam int COEFF_W    = 15;
    localparam int TAPCNT_W   = 13;
    localparam int TAPIDX_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREDELAY_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWPASS_COEFF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT      = 3'd5;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PD_MOD,
        ST_PD_READ,
        ST_PD_DATA,
        ST_HIST,
        ST_MAC,
        ST_DRAIN,
        ST_POST_WAIT,
        ST_POST_RUN
    } state_t;

    typedef struct packed {
        logic hist_we;
        logic rd_en;
        logic acc_clr;
    } lane_ctrl_t;

    function automatic logic signed [63:0] rnd15(input logic signed [63:0] x);
        return (x + 64'sd16384) >>> 15;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi)
        begin
            return hi[SAMPLE_W-1:0];
        end
        if (x < lo)
        begin
            return lo[SAMPLE_W-1:0];
        end
        return x[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/stereo_convolution_reverb.sv =====
// ----------------------------------------------------------------------------
// stereo_convolution_reverb
// stereo fir convolution reverb with predelay, width, lowpass and dry/wet mix
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    op, sample_left, sample_right,
//                                           tap_index, tap_value
// out       output     out_valid/out_ready  out_left, out_right
// cfg       input      cfg_write            cfg_index, cfg_data
//
// a load item writes the tap ram and leaves the block ready; a sample item runs
// the one-tap-per-cycle mac of each lane over n taps, n being tap_count clamped
// to MAX_TAPS; a nonzero predelay first folds a long predelay_len by steps of
// PREDELAY_DEPTH, then reads and writes the predelay rams
// after reset a clearing pass over max(MAX_TAPS, PREDELAY_DEPTH) addresses zeroes
// history and predelay rams; no item is taken meanwhile
// a new item is taken while a result waits in the output register; a
// stalled output holds the next result in the merge stage launch
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_convolution_reverb #(
    parameter int MAX_TAPS       = scr_pkg::DEF_MAX_TAPS,
    parameter int PREDELAY_DEPTH = scr_pkg::DEF_PREDELAY_DEPTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  op,
    input  wire logic signed [scr_pkg::SAMPLE_W-1:0]   sample_left,
    input  wire logic signed [scr_pkg::SAMPLE_W-1:0]   sample_right,
    input  wire logic [scr_pkg::TAPIDX_W-1:0]          tap_index,
    input  wire logic signed [scr_pkg::SAMPLE_W-1:0]   tap_value,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [scr_pkg::SAMPLE_W-1:0]        out_left,
    output logic signed [scr_pkg::SAMPLE_W-1:0]        out_right,
    input  wire logic                                  cfg_write,
    input  wire logic [scr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [scr_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int SW    = scr_pkg::SAMPLE_W;
    localparam int TAW   = $clog2(MAX_TAPS);
    localparam int DAW   = $clog2(PREDELAY_DEPTH);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int CLR_N = (MAX_TAPS > PREDELAY_DEPTH) ? MAX_TAPS : PREDELAY_DEPTH;
    localparam int CLR_W = $clog2(CLR_N);

    scr_pkg::state_t state_reg;
    scr_pkg::state_t state_next;

    logic [scr_pkg::MIX_W-1:0]      mix_gain_reg;
    logic [scr_pkg::PREDELAY_W-1:0] predelay_len_reg;
    logic [scr_pkg::WIDTH_W-1:0]    width_gain_reg;
    logic                           lowpass_enable_reg;
    logic [scr_pkg::COEFF_W-1:0]    lowpass_coeff_reg;
    logic [scr_pkg::TAPCNT_W-1:0]   tap_count_reg;

    logic [CLR_W-1:0]               clr_reg;
    logic [TAW-1:0]                 hptr_reg;
    logic [DAW-1:0]                 dptr_reg;
    logic [scr_pkg::PREDELAY_W-1:0] back_reg;
    logic [CNT_W-1:0]               idx_reg;
    logic [CNT_W-1:0]               n_reg;
    logic [1:0]                     drain_reg;
    logic signed [SW-1:0]           dry_l_reg;
    logic signed [SW-1:0]           dry_r_reg;
    logic signed [SW-1:0]           x_l_reg;
    logic signed [SW-1:0]           x_r_reg;
    logic                           out_valid_reg;
    logic signed [SW-1:0]           out_l_reg;
    logic signed [SW-1:0]           out_r_reg;

    logic                           in_fire;
    logic                           clr_last;
    logic                           back_big;
    logic [DAW-1:0]                 delay_raddr;
    logic [CNT_W-1:0]               n_clamp;
    scr_pkg::lane_ctrl_t            lane_ctrl;
    logic [TAW-1:0]                 hist_waddr;
    logic signed [SW-1:0]           hist_wdata_l;
    logic signed [SW-1:0]           hist_wdata_r;
    logic                           tap_we;
    logic                           delay_we;
    logic                           delay_re;
    logic [DAW-1:0]                 delay_waddr;
    logic signed [SW-1:0]           delay_wdata_l;
    logic signed [SW-1:0]           delay_wdata_r;
    logic [SW-1:0]                  delay_q_l;
    logic [SW-1:0]                  delay_q_r;
    logic [SW-1:0]                  tap_q;
    logic signed [SW-1:0]           wet_l;
    logic signed [SW-1:0]           wet_r;
    logic                           merge_start;
    logic                           merge_done;
    logic signed [SW-1:0]           merge_l;
    logic signed [SW-1:0]           merge_r;

    assign in_ready  = (state_reg == scr_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign clr_last  = (32'(clr_reg) == CLR_N - 1);
    assign back_big  = (32'(back_reg) >= PREDELAY_DEPTH);
    assign n_clamp   = (32'(tap_count_reg) > MAX_TAPS) ? CNT_W'(MAX_TAPS)
                                                       : CNT_W'(tap_count_reg);
    assign out_valid = out_valid_reg;
    assign out_left  = out_l_reg;
    assign out_right = out_r_reg;

    always_comb
    begin
        if (32'(dptr_reg) >= 32'(back_reg))
        begin
            delay_raddr = DAW'(32'(dptr_reg) - 32'(back_reg));
        end
        else
        begin
            delay_raddr = DAW'(32'(dptr_reg) + PREDELAY_DEPTH - 32'(back_reg));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scr_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = scr_pkg::ST_IDLE;
                end
            end
            scr_pkg::ST_IDLE:
            begin
                if (in_fire && op == scr_pkg::OP_SAMPLE)
                begin
                    state_next = (predelay_len_reg != '0) ? scr_pkg::ST_PD_MOD
                                                          : scr_pkg::ST_HIST;
                end
            end
            scr_pkg::ST_PD_MOD:
            begin
                if (!back_big)
                begin
                    state_next = scr_pkg::ST_PD_READ;
                end
            end
            scr_pkg::ST_PD_READ:   state_next = scr_pkg::ST_PD_DATA;
            scr_pkg::ST_PD_DATA:   state_next = scr_pkg::ST_HIST;
            scr_pkg::ST_HIST:
            begin
                state_next = (n_reg == '0) ? scr_pkg::ST_DRAIN : scr_pkg::ST_MAC;
            end
            scr_pkg::ST_MAC:
            begin
                if (idx_reg == n_reg - CNT_W'(1))
                begin
                    state_next = scr_pkg::ST_DRAIN;
                end
            end
            scr_pkg::ST_DRAIN:
            begin
                if (drain_reg == 2'd2)
                begin
                    state_next = scr_pkg::ST_POST_WAIT;
                end
            end
            scr_pkg::ST_POST_WAIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = scr_pkg::ST_POST_RUN;
                end
            end
            scr_pkg::ST_POST_RUN:
            begin
                if (merge_done)
                begin
                    state_next = scr_pkg::ST_IDLE;
                end
            end
            default:               state_next = scr_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        lane_ctrl     = '0;
        hist_waddr    = hptr_reg;
        hist_wdata_l  = x_l_reg;
        hist_wdata_r  = x_r_reg;
        tap_we        = 1'b0;
        delay_we      = 1'b0;
        delay_re      = 1'b0;
        delay_waddr   = dptr_reg;
        delay_wdata_l = dry_l_reg;
        delay_wdata_r = dry_r_reg;
        merge_start   = 1'b0;
        case (state_reg)
            scr_pkg::ST_CLEAR:
            begin
                lane_ctrl.hist_we = (32'(clr_reg) < MAX_TAPS);
                hist_waddr        = TAW'(clr_reg);
                hist_wdata_l      = '0;
                hist_wdata_r      = '0;
                delay_we          = (32'(clr_reg) < PREDELAY_DEPTH);
                delay_waddr       = DAW'(clr_reg);
                delay_wdata_l     = '0;
                delay_wdata_r     = '0;
            end
            scr_pkg::ST_IDLE:
            begin
                tap_we = in_fire && op == scr_pkg::OP_LOAD && (32'(tap_index) < MAX_TAPS);
            end
            scr_pkg::ST_PD_READ:
            begin
                delay_we = 1'b1;
                delay_re = 1'b1;
            end
            scr_pkg::ST_HIST:
            begin
                lane_ctrl.hist_we = 1'b1;
                lane_ctrl.acc_clr = 1'b1;
            end
            scr_pkg::ST_MAC:
            begin
                lane_ctrl.rd_en = 1'b1;
            end
            scr_pkg::ST_POST_WAIT:
            begin
                merge_start = !out_valid_reg || out_ready;
            end
            default:
            begin
                merge_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= scr_pkg::ST_CLEAR;
            clr_reg            <= '0;
            hptr_reg           <= '0;
            dptr_reg           <= '0;
            idx_reg            <= '0;
            drain_reg          <= '0;
            out_valid_reg      <= 1'b0;
            mix_gain_reg       <= 16'd16384;
            predelay_len_reg   <= '0;
            width_gain_reg     <= 16'd32768;
            lowpass_enable_reg <= 1'b0;
            lowpass_coeff_reg  <= '0;
            tap_count_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == scr_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + CLR_W'(1);
            end
            if (state_reg == scr_pkg::ST_PD_READ)
            begin
                dptr_reg <= (32'(dptr_reg) == PREDELAY_DEPTH - 1) ? '0
                                                                  : dptr_reg + DAW'(1);
            end
            if (state_reg == scr_pkg::ST_HIST)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == scr_pkg::ST_MAC)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (state_reg == scr_pkg::ST_DRAIN)
            begin
                drain_reg <= drain_reg + 2'd1;
                if (drain_reg == 2'd2)
                begin
                    drain_reg <= '0;
                    hptr_reg  <= (32'(hptr_reg) == MAX_TAPS - 1) ? '0 : hptr_reg + TAW'(1);
                end
            end
            if (merge_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    scr_pkg::REG_MIX_GAIN:       mix_gain_reg       <= cfg_data;
                    scr_pkg::REG_PREDELAY_LEN:   predelay_len_reg   <= cfg_data[12:0];
                    scr_pkg::REG_WIDTH_GAIN:     width_gain_reg     <= cfg_data;
                    scr_pkg::REG_LOWPASS_ENABLE: lowpass_enable_reg <= cfg_data[0];
                    scr_pkg::REG_LOWPASS_COEFF:  lowpass_coeff_reg  <= cfg_data[14:0];
                    scr_pkg::REG_TAP_COUNT:      tap_count_reg      <= cfg_data[12:0];
                    default:                     mix_gain_reg       <= mix_gain_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && op == scr_pkg::OP_SAMPLE)
        begin
            dry_l_reg <= sample_left;
            dry_r_reg <= sample_right;
            x_l_reg   <= sample_left;
            x_r_reg   <= sample_right;
            back_reg  <= predelay_len_reg;
            n_reg     <= n_clamp;
        end
        if (state_reg == scr_pkg::ST_PD_MOD && back_big)
        begin
            back_reg <= scr_pkg::PREDELAY_W'(32'(back_reg) - PREDELAY_DEPTH);
        end
        if (state_reg == scr_pkg::ST_PD_DATA)
        begin
            x_l_reg <= $signed(delay_q_l);
            x_r_reg <= $signed(delay_q_r);
        end
        if (merge_done)
        begin
            out_l_reg <= merge_l;
            out_r_reg <= merge_r;
        end
    end

    scr_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_TAPS)
    ) u_taps (
        .clk   (clk),
        .we    (tap_we),
        .waddr (TAW'(tap_index)),
        .wdata (tap_value),
        .re    (lane_ctrl.rd_en),
        .raddr (TAW'(idx_reg)),
        .rdata (tap_q)
    );

    scr_ram #(
        .WIDTH (SW),
        .DEPTH (PREDELAY_DEPTH)
    ) u_delay_l (
        .clk   (clk),
        .we    (delay_we),
        .waddr (delay_waddr),
        .wdata (delay_wdata_l),
        .re    (delay_re),
        .raddr (delay_raddr),
        .rdata (delay_q_l)
    );

    scr_ram #(
        .WIDTH (SW),
        .DEPTH (PREDELAY_DEPTH)
    ) u_delay_r (
        .clk   (clk),
        .we    (delay_we),
        .waddr (delay_waddr),
        .wdata (delay_wdata_r),
        .re    (delay_re),
        .raddr (delay_raddr),
        .rdata (delay_q_r)
    );

    scr_lane #(
        .MAX_TAPS (MAX_TAPS)
    ) u_lane_l (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lane_ctrl),
        .hist_waddr (hist_waddr),
        .hist_wdata (hist_wdata_l),
        .hptr       (hptr_reg),
        .tap_idx    (TAW'(idx_reg)),
        .tap        ($signed(tap_q)),
        .wet        (wet_l)
    );

    scr_lane #(
        .MAX_TAPS (MAX_TAPS)
    ) u_lane_r (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lane_ctrl),
        .hist_waddr (hist_waddr),
        .hist_wdata (hist_wdata_r),
        .hptr       (hptr_reg),
        .tap_idx    (TAW'(idx_reg)),
        .tap        ($signed(tap_q)),
        .wet        (wet_r)
    );

    scr_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (merge_start),
        .wet_l      (wet_l),
        .wet_r      (wet_r),
        .dry_l      (dry_l_reg),
        .dry_r      (dry_r_reg),
        .width_gain (width_gain_reg),
        .lp_en      (lowpass_enable_reg),
        .lp_coeff   (lowpass_coeff_reg),
        .mix_gain   (mix_gain_reg),
        .done       (merge_done),
        .out_l      (merge_l),
        .out_r      (merge_r)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/scr_ram.sv =====
// ----------------------------------------------------------------------------
// scr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module scr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scr_lane.sv =====
// ----------------------------------------------------------------------------
// scr_lane
// one channel of the fir: history ram and a pipelined multiply-accumulate
// ----------------------------------------------------------------------------
`default_nettype none

module scr_lane #(
    parameter int MAX_TAPS = scr_pkg::DEF_MAX_TAPS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire scr_pkg::lane_ctrl_t                 ctrl,
    input  wire logic [$clog2(MAX_TAPS)-1:0]         hist_waddr,
    input  wire logic signed [scr_pkg::SAMPLE_W-1:0] hist_wdata,
    input  wire logic [$clog2(MAX_TAPS)-1:0]         hptr,
    input  wire logic [$clog2(MAX_TAPS)-1:0]         tap_idx,
    input  wire logic signed [scr_pkg::SAMPLE_W-1:0] tap,
    output logic signed [scr_pkg::SAMPLE_W-1:0]      wet
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int PW    = 2 * scr_pkg::SAMPLE_W;
    localparam int ACC_W = PW + $clog2(MAX_TAPS) + 1;

    logic [AW-1:0]                        raddr;
    logic [scr_pkg::SAMPLE_W-1:0]         hist_q;
    logic                                 v1_reg;
    logic                                 v2_reg;
    logic signed [PW-1:0]                 prod_reg;
    logic signed [ACC_W-1:0]              acc_reg;
    logic signed [ACC_W-1:0]              acc_next;

    // read position walks backward from the newest sample
    always_comb
    begin
        if (hptr >= tap_idx)
        begin
            raddr = hptr - tap_idx;
        end
        else
        begin
            raddr = AW'(32'(hptr) + MAX_TAPS - 32'(tap_idx));
        end
    end

    scr_ram #(
        .WIDTH (scr_pkg::SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_hist (
        .clk   (clk),
        .we    (ctrl.hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (ctrl.rd_en),
        .raddr (raddr),
        .rdata (hist_q)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(hist_q) * tap;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg  <= ctrl.rd_en;
            v2_reg  <= v1_reg;
            acc_reg <= acc_next;
        end
    end

    assign wet = scr_pkg::sat16(scr_pkg::rnd15(64'(acc_reg)));

endmodule

`default_nettype wire

// ===== hw/rtl/scr_merge.sv =====
// ----------------------------------------------------------------------------
// scr_merge
// combines the lane results: stereo width, one-pole lowpass, dry/wet mix
// ----------------------------------------------------------------------------
`default_nettype none

module scr_merge (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [scr_pkg::SAMPLE_W-1:0] wet_l,
    input  wire logic signed [scr_pkg::SAMPLE_W-1:0] wet_r,
    input  wire logic signed [scr_pkg::SAMPLE_W-1:0] dry_l,
    input  wire logic signed [scr_pkg::SAMPLE_W-1:0] dry_r,
    input  wire logic [scr_pkg::WIDTH_W-1:0]         width_gain,
    input  wire logic                                lp_en,
    input  wire logic [scr_pkg::COEFF_W-1:0]         lp_coeff,
    input  wire logic [scr_pkg::MIX_W-1:0]           mix_gain,
    output logic                                     done,
    output logic signed [scr_pkg::SAMPLE_W-1:0]      out_l,
    output logic signed [scr_pkg::SAMPLE_W-1:0]      out_r
);

    localparam int SW = scr_pkg::SAMPLE_W;

    logic [6:0] v_reg;

    logic signed [SW-1:0] w0_reg [2];
    logic signed [SW-1:0] d0_reg [2];
    logic signed [SW-1:0] w1_reg [2];
    logic signed [SW-1:0] d1_reg [2];
    logic signed [SW:0]   mono1_reg;
    logic signed [35:0]   pw_reg [2];
    logic signed [SW-1:0] w2_reg [2];
    logic signed [SW-1:0] d2_reg [2];
    logic signed [34:0]   la_reg [2];
    logic signed [34:0]   lb_reg [2];
    logic signed [SW-1:0] w3_reg [2];
    logic signed [SW-1:0] d3_reg [2];
    logic signed [SW-1:0] w4_reg [2];
    logic signed [SW-1:0] d4_reg [2];
    logic signed [SW-1:0] smooth_reg [2];
    logic signed [35:0]   ma_reg [2];
    logic signed [35:0]   mb_reg [2];
    logic signed [SW-1:0] o_reg [2];

    logic signed [SW:0]   mono;
    logic                 width_on;
    logic [17:0]          mix_c;
    logic [17:0]          dry_c;
    logic [17:0]          lp_keep;

    assign mono     = (SW+1)'(($signed({w0_reg[0][SW-1], w0_reg[0]})
                      + $signed({w0_reg[1][SW-1], w0_reg[1]})) >>> 1);
    assign width_on = 32'(width_gain) < scr_pkg::ONE_Q15;
    assign mix_c    = (32'(mix_gain) > scr_pkg::ONE_Q15) ? 18'(scr_pkg::ONE_Q15)
                                                         : 18'(mix_gain);
    assign dry_c    = 18'(scr_pkg::ONE_Q15) - mix_c;
    assign lp_keep  = 18'(scr_pkg::ONE_Q15) - 18'(lp_coeff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[5:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            w0_reg[0] <= wet_l;
            w0_reg[1] <= wet_r;
            d0_reg[0] <= dry_l;
            d0_reg[1] <= dry_r;
        end
        if (v_reg[0])
        begin
            mono1_reg <= mono;
        end
    end

    for (genvar ch = 0; ch < 2; ch++)
    begin : g_ch
        always_ff @(posedge clk)
        begin
            if (v_reg[0])
            begin
                pw_reg[ch] <= ($signed({w0_reg[ch][SW-1], w0_reg[ch][SW-1], w0_reg[ch]})
                              - $signed({mono[SW], mono})) * $signed({1'b0, width_gain});
                w1_reg[ch] <= w0_reg[ch];
                d1_reg[ch] <= d0_reg[ch];
            end
            if (v_reg[1])
            begin
                w2_reg[ch] <= width_on
                    ? scr_pkg::sat16(64'(mono1_reg) + scr_pkg::rnd15(64'(pw_reg[ch])))
                    : w1_reg[ch];
                d2_reg[ch] <= d1_reg[ch];
            end
            if (v_reg[2])
            begin
                la_reg[ch] <= 35'(w2_reg[ch] * $signed(lp_keep));
                lb_reg[ch] <= 35'(smooth_reg[ch] * $signed({3'b000, lp_coeff}));
                w3_reg[ch] <= w2_reg[ch];
                d3_reg[ch] <= d2_reg[ch];
            end
            if (v_reg[3])
            begin
                w4_reg[ch] <= lp_en
                    ? scr_pkg::sat16(scr_pkg::rnd15(64'(la_reg[ch]) + 64'(lb_reg[ch])))
                    : w3_reg[ch];
                d4_reg[ch] <= d3_reg[ch];
            end
            if (v_reg[4])
            begin
                ma_reg[ch] <= 36'(d4_reg[ch] * $signed(dry_c));
                mb_reg[ch] <= 36'(w4_reg[ch] * $signed(mix_c));
            end
            if (v_reg[5])
            begin
                o_reg[ch] <= scr_pkg::sat16(scr_pkg::rnd15(64'(ma_reg[ch]) + 64'(mb_reg[ch])));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                smooth_reg[ch] <= '0;
            end
            else if (v_reg[3] && lp_en)
            begin
                smooth_reg[ch] <= scr_pkg::sat16(scr_pkg::rnd15(64'(la_reg[ch])
                                                              + 64'(lb_reg[ch])));
            end
        end
    end

    assign done  = v_reg[6];
    assign out_l = o_reg[0];
    assign out_r = o_reg[1];

endmodule

`default_nettype wire

// ===== hw/rtl/scr_checker.sv =====
// ----------------------------------------------------------------------------
// scr_checker
// port-level checks for the stereo reverb, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module scr_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         op,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [scr_pkg::SAMPLE_W-1:0] out_left,
    input wire logic [scr_pkg::SAMPLE_W-1:0] out_right
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_left) && $stable(out_right))
        else $error("output item changed while stalled");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == scr_pkg::OP_SAMPLE |=> !in_ready)
        else $error("sample item accepted without a busy period");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == scr_pkg::OP_LOAD && !out_valid |=> !out_valid)
        else $error("load item produced a result");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_ready)
        else $error("activity during reset");

endmodule

bind stereo_convolution_reverb scr_checker u_scr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_left  (out_left),
    .out_right (out_right)
);

`default_nettype wire

// ===== dv/tb_stereo_convolution_reverb.sv =====
// ----------------------------------------------------------------------------
// tb_stereo_convolution_reverb
// self-checking bench for the stereo convolution reverb: loads the impulse
// response taps in use, then steps through register settings (extremes
// included) with directed and random stereo samples and tap reloads under
// random input gaps and output stalls; a bit-exact predictor checks every result
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stereo_convolution_reverb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTAPS   = scr_pkg::DEF_MAX_TAPS;
    localparam int NDELAY  = scr_pkg::DEF_PREDELAY_DEPTH;
    localparam int ONE     = scr_pkg::ONE_Q15;
    localparam int NLOAD   = 48;
    localparam int MAX_CYC = 3000000;

    typedef logic signed [scr_pkg::SAMPLE_W-1:0] smp_t;

    typedef struct packed {
        smp_t left;
        smp_t right;
    } stereo_t;

    class reverb_scoreboard;
        smp_t        taps [NTAPS];
        smp_t        hist_l [NTAPS];
        smp_t        hist_r [NTAPS];
        smp_t        dly_l [NDELAY];
        smp_t        dly_r [NDELAY];
        int unsigned hist_ptr;
        int unsigned dly_ptr;
        longint      smooth_l;
        longint      smooth_r;
        longint      mix_gain;
        longint      predelay;
        longint      width_gain;
        bit          lp_en;
        longint      lp_coeff;
        longint      tap_count;
        stereo_t     pending [$];
        int          errors;

        function new();
            foreach (taps[i])
            begin
                taps[i] = '0;
                hist_l[i] = '0;
                hist_r[i] = '0;
            end
            foreach (dly_l[i])
            begin
                dly_l[i] = '0;
                dly_r[i] = '0;
            end
            hist_ptr = 0;
            dly_ptr = 0;
            smooth_l = 0;
            smooth_r = 0;
            mix_gain = 16384;
            predelay = 0;
            width_gain = ONE;
            lp_en = 0;
            lp_coeff = 0;
            tap_count = 0;
            errors = 0;
        endfunction

        function longint rnd(longint x);
            return (x + 64'sd16384) >>> 15;
        endfunction

        function longint clip(longint x);
            if (x > 32767)
            begin
                return 32767;
            end
            if (x < -32768)
            begin
                return -32768;
            end
            return x;
        endfunction

        function void write_reg(logic [scr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                scr_pkg::REG_MIX_GAIN:       mix_gain = val;
                scr_pkg::REG_PREDELAY_LEN:   predelay = val[12:0];
                scr_pkg::REG_WIDTH_GAIN:     width_gain = val;
                scr_pkg::REG_LOWPASS_ENABLE: lp_en = val[0];
                scr_pkg::REG_LOWPASS_COEFF:  lp_coeff = val[14:0];
                scr_pkg::REG_TAP_COUNT:      tap_count = val[12:0];
                default: ;
            endcase
        endfunction

        function void note_item(logic op, smp_t sl, smp_t sr, logic [11:0] idx, smp_t tv);
            longint      dl, dr, xl, xr, wl, wr, accl, accr, mono, m, n;
            int unsigned rd, pos;
            stereo_t     res;
            if (op == scr_pkg::OP_LOAD)
            begin
                taps[idx] = tv;
                return;
            end
            dl = sl;
            dr = sr;
            xl = dl;
            xr = dr;
            if (predelay != 0)
            begin
                rd = (dly_ptr + NDELAY - int'(predelay % NDELAY)) % NDELAY;
                xl = dly_l[rd];
                xr = dly_r[rd];
                dly_l[dly_ptr] = sl;
                dly_r[dly_ptr] = sr;
                dly_ptr = (dly_ptr + 1) % NDELAY;
            end
            hist_l[hist_ptr] = smp_t'(xl);
            hist_r[hist_ptr] = smp_t'(xr);
            n = (tap_count > NTAPS) ? NTAPS : tap_count;
            accl = 0;
            accr = 0;
            for (int i = 0; i < n; i++)
            begin
                pos = (hist_ptr + NTAPS - i) % NTAPS;
                accl += longint'(hist_l[pos]) * longint'(taps[i]);
                accr += longint'(hist_r[pos]) * longint'(taps[i]);
            end
            wl = clip(rnd(accl));
            wr = clip(rnd(accr));
            hist_ptr = (hist_ptr + 1) % NTAPS;
            if (width_gain < ONE)
            begin
                mono = (wl + wr) >>> 1;
                wl = clip(mono + rnd((wl - mono) * width_gain));
                wr = clip(mono + rnd((wr - mono) * width_gain));
            end
            if (lp_en)
            begin
                smooth_l = clip(rnd(wl * (ONE - lp_coeff) + smooth_l * lp_coeff));
                smooth_r = clip(rnd(wr * (ONE - lp_coeff) + smooth_r * lp_coeff));
                wl = smooth_l;
                wr = smooth_r;
            end
            m = (mix_gain > ONE) ? ONE : mix_gain;
            res.left = smp_t'(clip(rnd(dl * (ONE - m) + wl * m)));
            res.right = smp_t'(clip(rnd(dr * (ONE - m) + wr * m)));
            pending.push_back(res);
        endfunction

        function void check_result(smp_t ol, smp_t orr);
            stereo_t exp_res;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result left=%0d right=%0d", $time, ol, orr);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (ol !== exp_res.left)
            begin
                $display("%0t: out_left expected %0d actual %0d", $time, exp_res.left, ol);
                errors++;
            end
            if (orr !== exp_res.right)
            begin
                $display("%0t: out_right expected %0d actual %0d", $time, exp_res.right, orr);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = scr_pkg::OP_SAMPLE;
    smp_t        sample_left = '0;
    smp_t        sample_right = '0;
    logic [11:0] tap_index = '0;
    smp_t        tap_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    smp_t        out_left;
    smp_t        out_right;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    reverb_scoreboard sb;
    int  cycles = 0;
    int  out_stall = 0;
    bit  no_gaps = 0;
    bit  drain_each = 0;

    stereo_convolution_reverb u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .tap_index    (tap_index),
        .tap_value    (tap_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_left     (out_left),
        .out_right    (out_right),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 45)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic smp_t pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            default: return smp_t'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                sb.check_result(out_left, out_right);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                begin
                    out_stall = pick_gap();
                end
            end
        end
    end

    task automatic send_item(logic o, smp_t sl, smp_t sr, logic [11:0] idx, smp_t tv);
        int gap;
        gap = pick_gap();
        if (drain_each && sb.pending.size() != 0)
        begin
            in_valid <= 1'b0;
            while (sb.pending.size() != 0)
            begin
                @(posedge clk);
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        sample_left <= sl;
        sample_right <= sr;
        tap_index <= idx;
        tap_value <= tv;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_item(o, sl, sr, idx, tv);
    endtask

    task automatic send_sample(smp_t sl, smp_t sr);
        send_item(scr_pkg::OP_SAMPLE, sl, sr, 12'($urandom), smp_t'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
    endtask

    task automatic set_regs(int mg, int pd, int wg, int le, int lc, int tc);
        logic [15:0] vals [6];
        vals = '{16'(mg), 16'(pd), 16'(wg), 16'(le), 16'(lc), 16'(tc)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            sb.write_reg(3'(i), vals[i]);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                send_item(scr_pkg::OP_LOAD, smp_t'($urandom), smp_t'($urandom),
                          12'($urandom_range(0, NLOAD - 1)), pick_sample());
            end
            else
            begin
                send_sample(pick_sample(), pick_sample());
            end
        end
        wait_idle();
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every tap in use written before any read, extremes at the front
        no_gaps = 1;
        send_item(scr_pkg::OP_LOAD, '0, '0, 12'd0, 16'sh7fff);
        send_item(scr_pkg::OP_LOAD, '0, '0, 12'd1, 16'sh8000);
        for (int i = 2; i < NLOAD; i++)
        begin
            send_item(scr_pkg::OP_LOAD, '0, '0, 12'(i), smp_t'($urandom));
        end
        no_gaps = 0;
        wait_idle();

        // defaults: no taps, half mix
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample('0, '0);
        wait_idle();

        set_regs(16384, 0, 32768, 0, 0, 4);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000);
        send_item(scr_pkg::OP_LOAD, '0, '0, 12'd2, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh1234, 16'shedcb);
        wait_idle();

        set_regs(32768, 1, 0, 1, 32767, 16);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh7fff);
        run_random(12);

        set_regs(65535, 8191, 65535, 1, 0, 3);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000);
        run_random(8);

        // every loaded tap in use, then all but the last one
        set_regs(20000, 5, 16384, 0, 12345, NLOAD);
        run_random(3);
        set_regs(0, 3, 30000, 1, 16384, NLOAD - 1);
        run_random(2);

        // sender waits for every result before each item
        set_regs(24000, 2, 8000, 1, 30000, 9);
        drain_each = 1;
        run_random(10);
        drain_each = 0;

        for (int p = 0; p < 8; p++)
        begin
            no_gaps = (p == 2);
            set_regs($urandom_range(0, 32768), $urandom_range(0, 40), $urandom_range(0, 32768),
                     $urandom_range(0, 1), $urandom_range(0, 32767), $urandom_range(0, 40));
            run_random(6);
        end
        no_gaps = 0;

        wait_idle();
        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/scr_pkg.sv
hw/rtl/scr_ram.sv
hw/rtl/scr_lane.sv
hw/rtl/scr_merge.sv
hw/rtl/stereo_convolution_reverb.sv
hw/rtl/scr_checker.sv
dv/tb_stereo_convolution_reverb.sv
